// ===== rtl/rfsac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the channel-sweep activity monitor.
package rfsac_pkg;

  localparam int CHAN_W  = 7;
  localparam int HIT_W   = 8;
  localparam int SUM_W   = 15;
  localparam int LVL_W   = 8;
  localparam int PROD_W  = SUM_W + LVL_W;
  localparam int FIELD_W = 6;
  localparam int CNT_W   = 8;
  localparam int WGT_W   = 6;
  localparam int QUEUE_DEPTH = 2;

  // input commands
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_CANDLE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_COUNT  = 2'd0;
  localparam logic [1:0] REG_POWER_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_CARRIER_WEIGHT = 2'd2;
  localparam logic [1:0] REG_PACKET_WEIGHT  = 2'd3;

  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST  = 8'd126;
  localparam logic [WGT_W-1:0] POWER_WEIGHT_RST   = 6'd12;
  localparam logic [WGT_W-1:0] CARRIER_WEIGHT_RST = 6'd4;
  localparam logic [WGT_W-1:0] PACKET_WEIGHT_RST  = 6'd25;
  localparam logic [CNT_W-1:0] CHANNEL_COUNT_MAX  = 8'd128;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [WGT_W-1:0] power_weight;
    logic [WGT_W-1:0] carrier_weight;
    logic [WGT_W-1:0] packet_weight;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [HIT_W-1:0] hit;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAN_W-1:0]  channel;
    logic [HIT_W-1:0]   hit_score;
    logic               sweep_end;
    logic [FIELD_W-1:0] sweep_level;
    logic [FIELD_W-1:0] slot;
    logic [FIELD_W-1:0] open_level;
    logic [FIELD_W-1:0] high_level;
    logic [FIELD_W-1:0] low_level;
    logic [FIELD_W-1:0] close_level;
    logic [CHAN_W-1:0]  peak_channel;
    logic               last;
  } res_t;

endpackage

// ===== rtl/rfsac_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, scores samples and drops unused commands.
module rfsac_front import rfsac_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic       power_seen,
  input  logic       carrier_seen,
  input  logic       packet_ok,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic [HIT_W-1:0] hit;

  always_comb begin
    hit = '0;
    if (power_seen) begin
      hit = hit + HIT_W'(cfg.power_weight);
    end
    if (carrier_seen) begin
      hit = hit + HIT_W'(cfg.carrier_weight);
    end
    if (packet_ok) begin
      hit = hit + HIT_W'(cfg.packet_weight);
    end
  end

  assign in_stall      = q_full;
  // unused command is taken and dropped here
  assign push          = in_valid && !q_full && (cmd != CMD_UNUSED);
  assign push_item.cmd = cmd;
  assign push_item.hit = hit;

endmodule

// ===== rtl/rfsac_queue.sv =====
`timescale 1ns / 1ps
// Short item queue between the front end and the back end.
module rfsac_queue import rfsac_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  item_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full    = (count == (PW + 1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rfsac_back.sv =====
`timescale 1ns / 1ps
// Back end: sweep accumulation, level division, frame candle and history streaming.
module rfsac_back import rfsac_pkg::*; #(
  parameter int HISTORY_DEPTH = 42,
  parameter int LEVEL_MAX     = 40,
  parameter int SUM_CEILING   = 500
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  res
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0]     LAST_IDX = AW'(HISTORY_DEPTH - 1);
  localparam logic [SUM_W-1:0]  CEIL     = SUM_W'(SUM_CEILING);
  localparam logic [LVL_W-1:0]  LMAX     = LVL_W'(LEVEL_MAX);
  localparam logic [PROD_W:0]   RECIP    = (PROD_W + 1)'((64'd1 << PROD_W) / SUM_CEILING);
  localparam int BAR_W = 4 * FIELD_W;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIX, S_FIN, S_RD, S_EMIT} state_t;

  state_t               state;
  logic [CHAN_W-1:0]    scan_channel;
  logic [SUM_W-1:0]     sweep_sum;
  logic [LVL_W-1:0]     frame_open;
  logic [LVL_W-1:0]     frame_high;
  logic [LVL_W-1:0]     frame_low;
  logic [LVL_W-1:0]     frame_close;
  logic                 frame_had_sweep;
  logic [HIT_W-1:0]     frame_peak_hit;
  logic [CHAN_W-1:0]    peak_chan;
  logic [AW-1:0]        head;
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        rd_cnt;
  logic [HISTORY_DEPTH-1:0] valid_bits;
  logic [FIELD_W-1:0]   newest_close;
  logic [PROD_W-1:0]    div_rem;
  logic [LVL_W-1:0]     div_q;
  logic [CHAN_W-1:0]    hold_chan;
  logic [HIT_W-1:0]     hold_hit;

  logic [BAR_W-1:0]     history [HISTORY_DEPTH];
  logic [BAR_W-1:0]     rd_data;
  logic                 rd_vld;

  logic                 out_free;
  logic                 res_load;
  logic [CNT_W-1:0]     count_eff;
  logic [CNT_W-1:0]     next_pos;
  logic                 ended;
  logic [SUM_W-1:0]     sum_new;
  logic [SUM_W-1:0]     sum_clamped;
  logic                 peak_take;
  logic [CHAN_W-1:0]    peak_next;
  logic [2*PROD_W:0]    recip_prod;
  logic [PROD_W-1:0]    fix_rem;
  logic                 fix_up;
  logic                 hist_we;
  logic [BAR_W-1:0]     new_candle;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic res_t sample_res(input logic [CHAN_W-1:0] ch,
                                      input logic [HIT_W-1:0] hit_v,
                                      input logic done,
                                      input logic [FIELD_W-1:0] lvl,
                                      input logic [CHAN_W-1:0] peak);
    res_t r;
    r              = '0;
    r.kind         = KIND_SAMPLE;
    r.channel      = ch;
    r.hit_score    = hit_v;
    r.sweep_end    = done;
    r.sweep_level  = lvl;
    r.peak_channel = peak;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic res_t candle_res(input logic [FIELD_W-1:0] pos,
                                      input logic [BAR_W-1:0] bar,
                                      input logic [CHAN_W-1:0] peak,
                                      input logic fin);
    res_t r;
    r              = '0;
    r.kind         = KIND_CANDLE;
    r.slot         = pos;
    r.open_level   = bar[4*FIELD_W-1:3*FIELD_W];
    r.high_level   = bar[3*FIELD_W-1:2*FIELD_W];
    r.low_level    = bar[2*FIELD_W-1:FIELD_W];
    r.close_level  = bar[FIELD_W-1:0];
    r.peak_channel = peak;
    r.last         = fin;
    return r;
  endfunction

  function automatic res_t clear_res();
    res_t r;
    r      = '0;
    r.kind = KIND_CLEAR;
    r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    if (cfg.channel_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (cfg.channel_count > CHANNEL_COUNT_MAX) begin
      count_eff = CHANNEL_COUNT_MAX;
    end else begin
      count_eff = cfg.channel_count;
    end
  end

  assign out_free    = !out_valid || !out_stall;
  assign q_pop       = (state == S_IDLE) && q_valid && out_free;
  assign next_pos    = {1'b0, scan_channel} + 1'b1;
  assign ended       = (next_pos >= count_eff);
  assign sum_new     = sweep_sum + SUM_W'(q_item.hit);
  assign sum_clamped = (sum_new > CEIL) ? CEIL : sum_new;
  assign peak_take   = (q_item.hit > frame_peak_hit);
  assign peak_next   = peak_take ? scan_channel : peak_chan;
  assign recip_prod  = div_rem * RECIP;
  assign fix_rem     = div_rem - PROD_W'(div_q * CEIL);
  assign fix_up      = (fix_rem >= PROD_W'(CEIL));
  assign hist_we     = q_pop && (q_item.cmd == CMD_TICK);
  assign res_load    = (q_pop && (q_item.cmd == CMD_SAMPLE) && !ended) ||
                       (q_pop && (q_item.cmd == CMD_CLEAR)) ||
                       (((state == S_FIN) || (state == S_EMIT)) && out_free);
  // flat candle at the newest close when no sweep ended in the frame
  assign new_candle  = frame_had_sweep ?
                       {frame_open[FIELD_W-1:0], frame_high[FIELD_W-1:0],
                        frame_low[FIELD_W-1:0], frame_close[FIELD_W-1:0]} :
                       {4{newest_close}};

  always_ff @(posedge clk) begin
    if (hist_we) begin
      history[head] <= new_candle;
    end
    if (state == S_RD) begin
      rd_data <= history[rd_ptr];
      rd_vld  <= valid_bits[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      scan_channel    <= '0;
      sweep_sum       <= '0;
      frame_open      <= '0;
      frame_high      <= '0;
      frame_low       <= '1;
      frame_close     <= '0;
      frame_had_sweep <= 1'b0;
      frame_peak_hit  <= '0;
      peak_chan       <= '0;
      head            <= '0;
      valid_bits      <= '0;
      newest_close    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.cmd)
              CMD_SAMPLE: begin
                if (peak_take) begin
                  frame_peak_hit <= q_item.hit;
                  peak_chan      <= scan_channel;
                end
                hold_chan <= scan_channel;
                hold_hit  <= q_item.hit;
                if (ended) begin
                  scan_channel <= '0;
                  sweep_sum    <= '0;
                  div_rem      <= PROD_W'(sum_clamped);
                  state        <= S_MUL;
                end else begin
                  scan_channel <= next_pos[CHAN_W-1:0];
                  sweep_sum    <= sum_new;
                  res          <= sample_res(scan_channel, q_item.hit, 1'b0, '0, peak_next);
                end
              end
              CMD_TICK: begin
                head             <= ptr_inc(head);
                valid_bits[head] <= 1'b1;
                newest_close     <= new_candle[FIELD_W-1:0];
                frame_open       <= '0;
                frame_high       <= '0;
                frame_low        <= '1;
                frame_close      <= '0;
                frame_had_sweep  <= 1'b0;
                frame_peak_hit   <= '0;
                // oldest entry sits just after the one written now
                rd_ptr           <= ptr_inc(head);
                rd_cnt           <= '0;
                state            <= S_RD;
              end
              CMD_CLEAR: begin
                valid_bits   <= '0;
                newest_close <= '0;
                res          <= clear_res();
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          div_rem <= PROD_W'(div_rem[SUM_W-1:0] * LMAX);
          state   <= S_DIV;
        end
        S_DIV: begin
          // divide by the sum ceiling through its reciprocal; the estimate is at most one low
          div_q <= recip_prod[PROD_W +: LVL_W];
          state <= S_FIX;
        end
        S_FIX: begin
          if (fix_up) begin
            div_q <= div_q + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            if (!frame_had_sweep) begin
              frame_open <= div_q;
            end
            if (!frame_had_sweep || (div_q > frame_high)) begin
              frame_high <= div_q;
            end
            if (!frame_had_sweep || (div_q < frame_low)) begin
              frame_low <= div_q;
            end
            frame_close     <= div_q;
            frame_had_sweep <= 1'b1;
            res             <= sample_res(hold_chan, hold_hit, 1'b1, div_q[FIELD_W-1:0],
                                          peak_chan);
            state           <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            res <= candle_res(FIELD_W'(rd_cnt), rd_vld ? rd_data : '0, peak_chan,
                              rd_cnt == LAST_IDX);
            if (rd_cnt == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              rd_cnt <= rd_cnt + 1'b1;
              rd_ptr <= ptr_inc(rd_ptr);
              state  <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_frame_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_had_sweep |-> (frame_low == '1) && (frame_high == '0) &&
                         (frame_open == '0) && (frame_close == '0))
    else $error("frame levels not at their empty values");

  a_frame_order: assert property (@(posedge clk) disable iff (rst)
    frame_had_sweep |-> (frame_low <= frame_close) && (frame_close <= frame_high))
    else $error("frame close outside low..high");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (div_q <= LMAX))
    else $error("sweep level above maximum");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX)
    else $error("history head out of range");

endmodule

// ===== rtl/rf_sweep_activity_candle_history.sv =====
`timescale 1ns / 1ps
// Top level of the channel-sweep activity monitor with candle history.
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     cmd, power_seen, carrier_seen, packet_ok
//  result    out        out_valid / out_stall   kind .. last (12 fields)
//  config    in         cfg_write               cfg_index, cfg_data
//
// A sample that does not end a sweep loads its result as it is taken; one that ends
// a sweep first passes through the level multiply, reciprocal divide and correction.
// A frame tick reads each candle from the history memory, then loads it into the output
// register, for all HISTORY_DEPTH slots in turn; a clear loads its result as it is taken.
// Reset is synchronous; history entries read as zero through per-entry valid bits,
// so no clearing pass is needed. A two-item queue lets inputs be taken while the
// back end is stalled on its output.
module rf_sweep_activity_candle_history import rfsac_pkg::*; #(
  parameter int HISTORY_DEPTH = 42,
  parameter int LEVEL_MAX     = 40,
  parameter int SUM_CEILING   = 500
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CNT_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic               power_seen,
  input  logic               carrier_seen,
  input  logic               packet_ok,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [CHAN_W-1:0]  channel,
  output logic [HIT_W-1:0]   hit_score,
  output logic               sweep_end,
  output logic [FIELD_W-1:0] sweep_level,
  output logic [FIELD_W-1:0] slot,
  output logic [FIELD_W-1:0] open_level,
  output logic [FIELD_W-1:0] high_level,
  output logic [FIELD_W-1:0] low_level,
  output logic [FIELD_W-1:0] close_level,
  output logic [CHAN_W-1:0]  peak_channel,
  output logic               last
);

  cfg_t  cfg;
  logic  q_full;
  logic  push;
  item_t push_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_item;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count  <= CHANNEL_COUNT_RST;
      cfg.power_weight   <= POWER_WEIGHT_RST;
      cfg.carrier_weight <= CARRIER_WEIGHT_RST;
      cfg.packet_weight  <= PACKET_WEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT:  cfg.channel_count  <= cfg_data;
        REG_POWER_WEIGHT:   cfg.power_weight   <= cfg_data[WGT_W-1:0];
        REG_CARRIER_WEIGHT: cfg.carrier_weight <= cfg_data[WGT_W-1:0];
        REG_PACKET_WEIGHT:  cfg.packet_weight  <= cfg_data[WGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfsac_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .power_seen   (power_seen),
    .carrier_seen (carrier_seen),
    .packet_ok    (packet_ok),
    .cfg          (cfg),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  rfsac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  rfsac_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LEVEL_MAX     (LEVEL_MAX),
    .SUM_CEILING   (SUM_CEILING)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign kind         = res.kind;
  assign channel      = res.channel;
  assign hit_score    = res.hit_score;
  assign sweep_end    = res.sweep_end;
  assign sweep_level  = res.sweep_level;
  assign slot         = res.slot;
  assign open_level   = res.open_level;
  assign high_level   = res.high_level;
  assign low_level    = res.low_level;
  assign close_level  = res.close_level;
  assign peak_channel = res.peak_channel;
  assign last         = res.last;

endmodule

// ===== tb/sv/tb_rf_sweep_activity_candle_history.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the channel-sweep activity monitor with candle history.
module tb_rf_sweep_activity_candle_history;
  import rfsac_pkg::*;

  localparam int HIST_N      = 42;
  localparam int LVL_TOP     = 40;
  localparam int SUM_TOP     = 500;
  localparam int SETTLE      = 120;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 45;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pwr;
    logic       car;
    logic       pkt;
  } probe_t;

  typedef struct packed {
    logic [7:0] o;
    logic [7:0] h;
    logic [7:0] l;
    logic [7:0] c;
  } bar_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = REG_CHANNEL_COUNT;
  logic [CNT_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_SAMPLE;
  logic               power_seen = 1'b0;
  logic               carrier_seen = 1'b0;
  logic               packet_ok = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [CHAN_W-1:0]  channel;
  logic [HIT_W-1:0]   hit_score;
  logic               sweep_end;
  logic [FIELD_W-1:0] sweep_level;
  logic [FIELD_W-1:0] slot;
  logic [FIELD_W-1:0] open_level;
  logic [FIELD_W-1:0] high_level;
  logic [FIELD_W-1:0] low_level;
  logic [FIELD_W-1:0] close_level;
  logic [CHAN_W-1:0]  peak_channel;
  logic               last;

  // predictor configuration and state
  logic [7:0] span_cfg;
  logic [5:0] pwr_w, car_w, pkt_w;
  logic [6:0] scan_pos;
  logic [14:0] sweep_acc;
  logic [7:0] fr_open, fr_high, fr_low, fr_close, fr_peak_hit;
  logic       fr_had;
  logic [6:0] peak_ch;
  bar_t       chart [HIST_N];

  probe_t probe_backlog[$];
  res_t   chart_due[$];
  int     probes_sent = 0;
  int     probes_taken = 0;
  int     results_taken = 0;
  int     failures = 0;
  int     gap_max = 14;
  int     stall_max = 14;
  int     holds_asked = 0;
  int     cycle_count = 0;

  rf_sweep_activity_candle_history #(
    .HISTORY_DEPTH(HIST_N),
    .LEVEL_MAX(LVL_TOP),
    .SUM_CEILING(SUM_TOP)
  ) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic reset_chart();
    span_cfg    = CHANNEL_COUNT_RST;
    pwr_w       = POWER_WEIGHT_RST;
    car_w       = CARRIER_WEIGHT_RST;
    pkt_w       = PACKET_WEIGHT_RST;
    scan_pos    = '0;
    sweep_acc   = '0;
    fr_open     = '0;
    fr_high     = '0;
    fr_low      = 8'd255;
    fr_close    = '0;
    fr_had      = 1'b0;
    fr_peak_hit = '0;
    peak_ch     = '0;
    for (int i = 0; i < HIST_N; i++) chart[i] = '0;
  endtask

  // Work out the results of one accepted item and queue them.
  task automatic sweep_chart_step(input logic [1:0] c, input logic pw_f, input logic cw_f,
                                  input logic pk_f);
    res_t        r;
    bar_t        fresh;
    int unsigned hit, span, nxt, s;
    logic [6:0]  here;
    logic [7:0]  lvl;
    logic        ended;
    case (c)
      CMD_SAMPLE: begin
        span = (span_cfg == 0) ? 1 :
               (span_cfg > CHANNEL_COUNT_MAX) ? CHANNEL_COUNT_MAX : span_cfg;
        hit = 0;
        if (pw_f) hit += pwr_w;
        if (cw_f) hit += car_w;
        if (pk_f) hit += pkt_w;
        here = scan_pos;
        sweep_acc = 15'(sweep_acc + hit);
        if (hit > fr_peak_hit) begin
          fr_peak_hit = 8'(hit);
          peak_ch = here;
        end
        nxt = here + 1;
        ended = 1'b0;
        lvl = '0;
        // a position left beyond a lowered count also ends the sweep
        if (nxt >= span) begin
          nxt = 0;
          ended = 1'b1;
          s = sweep_acc;
          if (s > SUM_TOP) s = SUM_TOP;
          lvl = 8'(s * LVL_TOP / SUM_TOP);
          if (!fr_had) begin
            fr_open = lvl;
            fr_high = lvl;
            fr_low  = lvl;
            fr_had  = 1'b1;
          end
          if (lvl > fr_high) fr_high = lvl;
          if (lvl < fr_low) fr_low = lvl;
          fr_close = lvl;
          sweep_acc = '0;
        end
        scan_pos = 7'(nxt);
        r = '0;
        r.kind = KIND_SAMPLE;
        r.channel = here;
        r.hit_score = 8'(hit);
        r.sweep_end = ended;
        r.sweep_level = lvl[5:0];
        r.peak_channel = peak_ch;
        r.last = 1'b1;
        chart_due.push_back(r);
      end
      CMD_TICK: begin
        // no sweep this frame: repeat the newest close as a flat candle
        if (fr_had) fresh = {fr_open, fr_high, fr_low, fr_close};
        else fresh = {4{chart[HIST_N-1].c}};
        for (int i = 0; i < HIST_N - 1; i++) chart[i] = chart[i+1];
        chart[HIST_N-1] = fresh;
        fr_open = '0;
        fr_high = '0;
        fr_low = 8'd255;
        fr_close = '0;
        fr_had = 1'b0;
        fr_peak_hit = '0;
        for (int i = 0; i < HIST_N; i++) begin
          r = '0;
          r.kind = KIND_CANDLE;
          r.slot = 6'(i);
          r.open_level = chart[i].o[5:0];
          r.high_level = chart[i].h[5:0];
          r.low_level = chart[i].l[5:0];
          r.close_level = chart[i].c[5:0];
          r.peak_channel = peak_ch;
          r.last = (i == HIST_N - 1);
          chart_due.push_back(r);
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < HIST_N; i++) chart[i] = '0;
        r = '0;
        r.kind = KIND_CLEAR;
        r.last = 1'b1;
        chart_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic string show_result(input res_t r);
    return $sformatf({"kind=%0d ch=%0d hit=%0d end=%0d lvl=%0d slot=%0d ",
                      "ohlc=%0d/%0d/%0d/%0d peak=%0d last=%0d"},
                     r.kind, r.channel, r.hit_score, r.sweep_end, r.sweep_level, r.slot,
                     r.open_level, r.high_level, r.low_level, r.close_level,
                     r.peak_channel, r.last);
  endfunction

  task automatic log_fault(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Driver: present the next item after its drawn gap, hold it until taken.
  always @(negedge clk) begin : drive
    probe_t p;
    int     idle_left;
    if (!rst && probes_taken == probes_sent) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (probe_backlog.size() > 0) begin
        p = probe_backlog.pop_front();
        cmd <= p.cmd;
        power_seen <= p.pwr;
        carrier_seen <= p.car;
        packet_ok <= p.pkt;
        in_valid <= 1'b1;
        probes_sent++;
        idle_left = $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a drawn number of cycles after each result, or a long hold on request.
  always @(negedge clk) begin : receive
    int hold_left;
    int stall_left;
    int holds_served;
    int results_seen;
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (results_seen != results_taken) begin
      results_seen = results_taken;
      stall_left = $urandom_range(0, stall_max);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted item first, then check each accepted result.
  always @(posedge clk) begin : watch
    res_t seen, want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        probes_taken++;
        sweep_chart_step(cmd, power_seen, carrier_seen, packet_ok);
      end
      if (out_valid && !out_stall) begin
        results_taken++;
        seen = {kind, channel, hit_score, sweep_end, sweep_level, slot, open_level,
                high_level, low_level, close_level, peak_channel, last};
        if (chart_due.size() == 0) begin
          log_fault($sformatf("unexpected result: %s", show_result(seen)));
        end else begin
          want = chart_due.pop_front();
          if (seen !== want)
            log_fault($sformatf("mismatch: expected %s, got %s",
                                show_result(want), show_result(seen)));
        end
      end
    end
  end

  task automatic push_probe(input logic [1:0] c, input logic [2:0] flags);
    probe_t p;
    p.cmd = c;
    p.pwr = flags[2];
    p.car = flags[1];
    p.pkt = flags[0];
    probe_backlog.push_back(p);
  endtask

  task automatic push_random_probe();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 84) push_probe(CMD_SAMPLE, 3'($urandom_range(0, 7)));
    else if (roll < 90) push_probe(CMD_TICK, 3'($urandom_range(0, 7)));
    else if (roll < 95) push_probe(CMD_CLEAR, 3'($urandom_range(0, 7)));
    else push_probe(CMD_UNUSED, 3'($urandom_range(0, 7)));
  endtask

  // Hold until every item is taken and every result has arrived, then let the block settle.
  task automatic wait_idle();
    while (probe_backlog.size() != 0 || probes_taken != probes_sent || chart_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CHANNEL_COUNT:  span_cfg = val;
      REG_POWER_WEIGHT:   pwr_w = val[5:0];
      REG_CARRIER_WEIGHT: car_w = val[5:0];
      REG_PACKET_WEIGHT:  pkt_w = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] span, input logic [7:0] pw, input logic [7:0] cw,
                           input logic [7:0] kw);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, span);
    write_reg(REG_POWER_WEIGHT, pw);
    write_reg(REG_CARRIER_WEIGHT, cw);
    write_reg(REG_PACKET_WEIGHT, kw);
  endtask

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd63;
      2: return {2'b11, 6'($urandom_range(0, 63))};
      default: return 8'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [7:0] pick_span();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return CHANNEL_COUNT_MAX;
      3: return 8'($urandom_range(129, 255));
      default: return 8'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    reset_chart();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset weights: every flag combination, an unused command, a tick with no sweep, a clear
    for (int f = 0; f < 8; f++) push_probe(CMD_SAMPLE, 3'(f));
    push_probe(CMD_UNUSED, 3'b111);
    push_probe(CMD_TICK, 3'b000);
    push_probe(CMD_CLEAR, 3'b000);

    // zero count acts as one; the scan position left past it ends the next sweep
    configure(8'd0, 8'd63, 8'd63, 8'd63);
    push_probe(CMD_SAMPLE, 3'b111);
    push_probe(CMD_SAMPLE, 3'b000);
    push_probe(CMD_TICK, 3'b000);
    push_probe(CMD_TICK, 3'b000);

    // sum over the ceiling clamps to the top level
    configure(8'd3, 8'd63, 8'd63, 8'd63);
    repeat (3) push_probe(CMD_SAMPLE, 3'b111);
    push_probe(CMD_TICK, 3'b000);
    push_probe(CMD_CLEAR, 3'b000);
    push_probe(CMD_TICK, 3'b000);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(8'd255, pick_weight(), pick_weight(), pick_weight());
        1: configure(8'd2, 8'd63, 8'd0, 8'd63);
        2: configure(CHANNEL_COUNT_MAX, pick_weight(), pick_weight(), pick_weight());
        default: configure(pick_span(), pick_weight(), pick_weight(), pick_weight());
      endcase
      case (ph)
        0: begin
          gap_max = 0;
          stall_max = 0;
        end
        1: begin
          gap_max = 0;
          stall_max = 14;
        end
        default: begin
          gap_max = (ph % 3 == 2) ? 0 : 14;
          stall_max = (ph % 4 == 3) ? 0 : 14;
        end
      endcase
      if (ph == 1) begin
        // block the output for a long stretch while ticks back up the input
        holds_asked++;
        push_probe(CMD_TICK, 3'b000);
        push_probe(CMD_TICK, 3'b000);
        for (int n = 2; n < PHASE_ITEMS; n++) push_random_probe();
      end else begin
        for (int n = 0; n < PHASE_ITEMS; n++) push_random_probe();
      end
    end

    wait_idle();
    failures += chart_due.size();
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
